### rtl/sfws_pkg.sv
// Package for the SPI flash write sequencer: phase codes, result kinds,
// input function codes and flash command bytes. No dependencies.
`default_nettype none
package sfws_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RD_HDR, PH_RD_DATA, PH_ER_WREN, PH_ER_HDR,
        PH_EP_CMD, PH_EP_STAT, PH_PG_WREN, PH_PG_HDR, PH_PG_WAIT,
        PH_PG_DATA, PH_PP_CMD, PH_PP_STAT
    } t_phase;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_RX    = 2'd1;
    localparam logic [1:0] FUNC_DATA  = 2'd2;

    localparam logic [1:0] KIND_SPI   = 2'd0;
    localparam logic [1:0] KIND_REQ   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_RDSR   = 8'h05;
    localparam logic [7:0] CMD_PP     = 8'h02;
    localparam logic [7:0] CMD_SE     = 8'h20;
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] BYTE_ERASED = 8'hFF;

    localparam int PG_LOG_MIN  = 4;
    localparam int PG_LOG_MAX  = 12;
    localparam int SEC_LOG_MIN = 10;
    localparam int SEC_LOG_MAX = 16;

endpackage
`default_nettype wire

### rtl/sfws_core.sv
// Sequencer state and next-result logic for the SPI flash write sequencer.
// Depends on sfws_pkg. Gives zero or one result per transfer taken, from registered state.
`default_nettype none
module sfws_core #(
    parameter int CHECK_CHUNK = 64,
    parameter int ADDR_BITS   = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_take,
    input  wire logic [1:0]           i_func,
    input  wire logic [23:0]          i_start_address,
    input  wire logic [23:0]          i_byte_count,
    input  wire logic [7:0]           i_rx_byte,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [3:0]           i_pg_log,
    input  wire logic [4:0]           i_sec_log,
    output logic                      o_emit,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_tx_byte,
    output logic                      o_frame_end,
    output logic [23:0]               o_data_index
);
    localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
    localparam int FBW = $clog2(ADDR_BYTES + 1);
    localparam int CKW = $clog2(CHECK_CHUNK + 1);

    sfws_pkg::t_phase r_phase, n_phase;
    logic [23:0] r_cur, n_cur, r_left, n_left, r_host, n_host;
    logic [16:0] r_seg, n_seg, r_chk, n_chk;
    logic [CKW-1:0] r_chunk, n_chunk;
    logic [12:0] r_page, n_page;
    logic [FBW-1:0] r_fbc, n_fbc;
    logic r_dirty, n_dirty;

    logic [3:0]  pl;
    logic [4:0]  sl;
    logic [16:0] sec_mask;
    logic [12:0] pg_mask;
    logic [23:0] rd_addr, er_base;

    // Saturate the size registers
    always_comb begin
        pl = i_pg_log;
        if (pl < 4'(sfws_pkg::PG_LOG_MIN)) pl = 4'(sfws_pkg::PG_LOG_MIN);
        if (pl > 4'(sfws_pkg::PG_LOG_MAX)) pl = 4'(sfws_pkg::PG_LOG_MAX);
        sl = i_sec_log;
        if (sl < 5'(sfws_pkg::SEC_LOG_MIN)) sl = 5'(sfws_pkg::SEC_LOG_MIN);
        if (sl > 5'(sfws_pkg::SEC_LOG_MAX)) sl = 5'(sfws_pkg::SEC_LOG_MAX);
        sec_mask = (17'd1 << sl) - 17'd1;
        pg_mask  = 13'((14'd1 << pl) - 14'd1);
        rd_addr  = r_cur + 24'(r_chk);
        er_base  = r_cur & ~{7'd0, sec_mask};
    end

    function automatic logic [7:0] addr_byte(input logic [23:0] a,
                                             input logic [FBW-1:0] k);
        int sh;
        logic [31:0] w;
        sh = 8 * (ADDR_BYTES - 1 - int'(k));
        w = {8'd0, a};
        if (sh > 31 || sh < 0) addr_byte = 8'd0;
        else addr_byte = 8'(w >> sh);
    endfunction

    // Next state and result
    always_comb begin
        logic [16:0] room_s, seg_v, rem;
        logic [12:0] room_p;
        logic [16:0] seg_src;
        logic [23:0] cur_src;
        logic        bseg, bpage, bread;
        logic [CKW-1:0] ck;
        n_phase = r_phase; n_cur = r_cur; n_left = r_left; n_host = r_host;
        n_seg = r_seg; n_chk = r_chk; n_chunk = r_chunk; n_page = r_page;
        n_fbc = r_fbc; n_dirty = r_dirty;
        o_emit = 1'b0; o_kind = sfws_pkg::KIND_SPI; o_tx_byte = 8'd0;
        o_frame_end = 1'b0; o_data_index = 24'd0;
        bseg = 1'b0; bpage = 1'b0; bread = 1'b0;
        cur_src = r_cur; seg_src = r_seg;
        room_s = 17'd0; seg_v = 17'd0; rem = 17'd0; room_p = 13'd0; ck = '0;

        if (i_take) begin
            case (i_func)
                sfws_pkg::FUNC_START: begin
                    if (r_phase == sfws_pkg::PH_IDLE) begin
                        n_cur = i_start_address; n_left = i_byte_count;
                        n_host = 24'd0; cur_src = i_start_address;
                        o_emit = 1'b1;
                        if (i_byte_count == 24'd0) begin
                            o_kind = sfws_pkg::KIND_DONE;
                        end else begin
                            bseg = 1'b1;
                        end
                    end
                end
                sfws_pkg::FUNC_DATA: begin
                    if (r_phase == sfws_pkg::PH_PG_WAIT) begin
                        n_phase = sfws_pkg::PH_PG_DATA;
                        o_emit = 1'b1; o_tx_byte = i_data_byte;
                        o_frame_end = (r_page == 13'd1);
                    end
                end
                sfws_pkg::FUNC_RX: begin
                    case (r_phase)
                        sfws_pkg::PH_RD_HDR: begin
                            o_emit = 1'b1;
                            if (int'(r_fbc) < ADDR_BYTES) begin
                                o_tx_byte = addr_byte(rd_addr, r_fbc);
                                n_fbc = r_fbc + 1'b1;
                            end else begin
                                n_phase = sfws_pkg::PH_RD_DATA;
                                o_tx_byte = sfws_pkg::BYTE_ERASED;
                                o_frame_end = (r_chunk == CKW'(1));
                            end
                        end
                        sfws_pkg::PH_RD_DATA: begin
                            n_dirty = r_dirty | (i_rx_byte != sfws_pkg::BYTE_ERASED);
                            n_chk = r_chk + 17'd1;
                            n_chunk = r_chunk - 1'b1;
                            o_emit = 1'b1;
                            if (n_chunk != '0) begin
                                o_tx_byte = sfws_pkg::BYTE_ERASED;
                                o_frame_end = (n_chunk == CKW'(1));
                            end else if (n_dirty) begin
                                n_phase = sfws_pkg::PH_ER_WREN;
                                o_tx_byte = sfws_pkg::CMD_WREN;
                                o_frame_end = 1'b1;
                            end else if (n_chk < r_seg) begin
                                bread = 1'b1;
                            end else begin
                                bpage = 1'b1;
                            end
                        end
                        sfws_pkg::PH_ER_WREN: begin
                            n_fbc = '0; n_phase = sfws_pkg::PH_ER_HDR;
                            o_emit = 1'b1; o_tx_byte = sfws_pkg::CMD_SE;
                        end
                        sfws_pkg::PH_ER_HDR: begin
                            o_emit = 1'b1;
                            if (int'(r_fbc) < ADDR_BYTES) begin
                                o_tx_byte = addr_byte(er_base, r_fbc);
                                n_fbc = r_fbc + 1'b1;
                                o_frame_end = (int'(r_fbc) == ADDR_BYTES - 1);
                            end else begin
                                n_phase = sfws_pkg::PH_EP_CMD;
                                o_tx_byte = sfws_pkg::CMD_RDSR;
                            end
                        end
                        sfws_pkg::PH_EP_CMD, sfws_pkg::PH_PP_CMD: begin
                            n_phase = (r_phase == sfws_pkg::PH_EP_CMD) ?
                                sfws_pkg::PH_EP_STAT : sfws_pkg::PH_PP_STAT;
                            o_emit = 1'b1; o_tx_byte = sfws_pkg::BYTE_ERASED;
                            o_frame_end = 1'b1;
                        end
                        sfws_pkg::PH_EP_STAT: begin
                            o_emit = 1'b1;
                            if (i_rx_byte[0]) begin
                                n_phase = sfws_pkg::PH_EP_CMD;
                                o_tx_byte = sfws_pkg::CMD_RDSR;
                            end else begin
                                bpage = 1'b1;
                            end
                        end
                        sfws_pkg::PH_PG_WREN: begin
                            n_fbc = '0; n_phase = sfws_pkg::PH_PG_HDR;
                            o_emit = 1'b1; o_tx_byte = sfws_pkg::CMD_PP;
                        end
                        sfws_pkg::PH_PG_HDR: begin
                            o_emit = 1'b1;
                            if (int'(r_fbc) < ADDR_BYTES) begin
                                o_tx_byte = addr_byte(r_cur, r_fbc);
                                n_fbc = r_fbc + 1'b1;
                            end else begin
                                n_phase = sfws_pkg::PH_PG_WAIT;
                                o_kind = sfws_pkg::KIND_REQ;
                                o_data_index = r_host;
                            end
                        end
                        sfws_pkg::PH_PG_DATA: begin
                            n_host = r_host + 24'd1; n_cur = r_cur + 24'd1;
                            n_left = r_left - 24'd1; n_seg = r_seg - 17'd1;
                            n_page = r_page - 13'd1;
                            o_emit = 1'b1;
                            if (n_page != 13'd0) begin
                                n_phase = sfws_pkg::PH_PG_WAIT;
                                o_kind = sfws_pkg::KIND_REQ;
                                o_data_index = n_host;
                            end else begin
                                n_phase = sfws_pkg::PH_PP_CMD;
                                o_tx_byte = sfws_pkg::CMD_RDSR;
                            end
                        end
                        sfws_pkg::PH_PP_STAT: begin
                            o_emit = 1'b1;
                            if (i_rx_byte[0]) begin
                                n_phase = sfws_pkg::PH_PP_CMD;
                                o_tx_byte = sfws_pkg::CMD_RDSR;
                            end else if (r_seg != 17'd0) begin
                                bpage = 1'b1;
                            end else if (r_left != 24'd0) begin
                                bseg = 1'b1;
                            end else begin
                                o_kind = sfws_pkg::KIND_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        // Start a sector segment: clip to sector room, open a read frame
        if (bseg) begin
            room_s = (sec_mask - (cur_src[16:0] & sec_mask)) + 17'd1;
            seg_v = ({7'd0, room_s} > n_left) ? n_left[16:0] : room_s;
            if (sl == 5'd16 && (cur_src[15:0] == 16'd0) && n_left >= 24'h10000)
                seg_v = 17'h10000;
            n_seg = seg_v; n_chk = 17'd0; n_dirty = 1'b0;
            seg_src = seg_v; bread = 1'b1;
        end
        if (bread) begin
            rem = seg_src - n_chk;
            ck = (rem < 17'(CHECK_CHUNK)) ? CKW'(rem) : CKW'(CHECK_CHUNK);
            n_chunk = ck; n_fbc = '0; n_phase = sfws_pkg::PH_RD_HDR;
            o_tx_byte = sfws_pkg::CMD_READ; o_frame_end = 1'b0;
        end
        // Start a program page: clip to page room, send write enable
        if (bpage) begin
            room_p = (pg_mask - (r_cur[12:0] & pg_mask)) + 13'd1;
            if (pl == 4'd12 && r_cur[11:0] == 12'd0) room_p = 13'h1000;
            n_page = ({4'd0, room_p} > n_seg) ? n_seg[12:0] : room_p;
            n_phase = sfws_pkg::PH_PG_WREN;
            o_tx_byte = sfws_pkg::CMD_WREN; o_frame_end = 1'b1;
        end
        if (o_kind == sfws_pkg::KIND_DONE && o_emit) n_phase = sfws_pkg::PH_IDLE;
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfws_pkg::PH_IDLE;
            r_cur <= '0; r_left <= '0; r_host <= '0; r_seg <= '0; r_chk <= '0;
            r_chunk <= '0; r_page <= '0; r_fbc <= '0; r_dirty <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cur <= n_cur; r_left <= n_left; r_host <= n_host; r_seg <= n_seg;
            r_chk <= n_chk; r_chunk <= n_chunk; r_page <= n_page;
            r_fbc <= n_fbc; r_dirty <= n_dirty;
        end
    end
endmodule
`default_nettype wire

### rtl/spi_flash_write_sequencer.sv
// SPI flash write sequencer top level: input register, sequencer core, result
// register with skid stage. Depends on sfws_pkg and sfws_core.
// Transfers are held in the input register, results in the result register.
// Throughput: one transfer per cycle while results drain; the input stalls only
// when the skid entry and the input register are both full.
// Reset (synchronous, active low) returns to idle, size registers to 8 and 12.
`default_nettype none
module spi_flash_write_sequencer #(
    parameter int CHECK_CHUNK = 64,
    parameter int ADDR_BITS   = 24
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [23:0] i_start_address,
    input  wire logic [23:0] i_byte_count,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_frame_end,
    output logic [23:0]      o_data_index,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [4:0]  i_cfg_data
);
    logic [3:0] r_pg_log;
    logic [4:0] r_sec_log;
    logic r_in_v;
    logic [1:0] r_func;
    logic [23:0] r_sa, r_bc;
    logic [7:0] r_rx, r_db;
    logic take;
    logic emit;
    logic [1:0] kind;
    logic [7:0] txb;
    logic fend;
    logic [23:0] didx;
    logic r_sk_v;
    logic [34:0] r_sk;
    logic [34:0] core_res;
    logic out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg_log <= 4'd8; r_sec_log <= 5'd12;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_pg_log <= i_cfg_data[3:0];
            else r_sec_log <= i_cfg_data;
        end
    end

    // Input register: hold the transfer while the skid entry is full
    assign take = r_in_v && !r_sk_v;
    assign o_stall = r_in_v && r_sk_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (!o_stall) begin
            r_in_v <= i_valid;
        end
        if (!o_stall) begin
            r_func <= i_func; r_sa <= i_start_address; r_bc <= i_byte_count;
            r_rx <= i_rx_byte; r_db <= i_data_byte;
        end
    end

    sfws_core #(.CHECK_CHUNK(CHECK_CHUNK), .ADDR_BITS(ADDR_BITS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_func(r_func),
        .i_start_address(r_sa), .i_byte_count(r_bc), .i_rx_byte(r_rx),
        .i_data_byte(r_db), .i_pg_log(r_pg_log), .i_sec_log(r_sec_log),
        .o_emit(emit), .o_kind(kind), .o_tx_byte(txb), .o_frame_end(fend),
        .o_data_index(didx)
    );

    assign core_res = {kind, txb, fend, didx};
    assign out_free = !o_valid || !i_stall;

    // Result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0; r_sk_v <= 1'b0;
        end else begin
            if (out_free) begin
                o_valid <= r_sk_v || emit;
                r_sk_v <= 1'b0;
            end else if (emit) begin
                r_sk_v <= 1'b1;
            end
        end
        if (out_free) begin
            {o_result_kind, o_tx_byte, o_frame_end, o_data_index} <=
                r_sk_v ? r_sk : core_res;
            if (r_sk_v) r_sk <= core_res;
        end else if (emit) begin
            r_sk <= core_res;
        end
    end
endmodule
`default_nettype wire
